[rtl/rtef_pkg.sv]
// Shared types and constants for the resistive touch event filter.
// No dependencies; used by rtl/resistive_touch_event_filter_core.sv.
`timescale 1ns / 1ps

package rtef_pkg;

    localparam int unsigned RAW_W       = 10;   // raw ADC, pixel and pressure width
    localparam int unsigned TIME_W      = 32;   // millisecond timestamp width
    localparam int unsigned PROD_W      = 2 * RAW_W;  // |raw - from| * size
    localparam int unsigned CNT_W       = 5;    // holds PROD_W - 1
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned IN_TDATA_W  = 64;   // 62 payload bits, byte padded
    localparam int unsigned OUT_TDATA_W = 40;   // 34 payload bits, byte padded

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAL_LEFT     = 3'd0,
        CFG_CAL_RIGHT    = 3'd1,
        CFG_CAL_TOP      = 3'd2,
        CFG_CAL_BOTTOM   = 3'd3,
        CFG_PRESSURE_MIN = 3'd4,
        CFG_PRESSURE_MAX = 3'd5,
        CFG_ORIENTATION  = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ORIENT_PORTRAIT      = 2'd0,
        ORIENT_LANDSCAPE     = 2'd1,
        ORIENT_PORTRAIT_INV  = 2'd2,
        ORIENT_LANDSCAPE_INV = 2'd3
    } t_orient;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_DIV,
        ST_STORE,
        ST_DONE
    } t_state;

endpackage

[rtl/resistive_touch_event_filter_core.sv]
// Resistive touch event filter: validates, maps and debounces raw touch samples.
// Depends on rtl/rtef_pkg.sv (widths, register indexes, orientation and state codes).
`timescale 1ns / 1ps

// Channel    | Dir | Handshake                  | Contents
// -----------+-----+----------------------------+--------------------------------------
// s_axis     | in  | i_s_axis_tvalid/o_..tready | one raw sample per transaction
// m_axis     | out | o_m_axis_tvalid/i_..tready | one filtered result per transaction
// cfg        | in  | i_cfg_wr_en (no wait)      | calibration, pressure window, orientation
//
// A sample with a valid touch passes, for each of the two axes, through a setup
// state, a multiply state, a bit-serial restoring divider (one quotient bit per
// cycle) and a clamp state, then a state that updates the touch state and loads
// the output register once free. A sample without a valid touch goes straight there.
// One sample is in flight at a time; the next is accepted once the previous result
// has moved to the output register, even while that result still waits on tready.
// Reset is synchronous, active low; it restores the configuration, state machine and
// touch state registers and the output valid flag, but not the sample or datapath ones.

module resistive_touch_event_filter_core #(
    parameter int unsigned PANEL_WIDTH  = 240,
    parameter int unsigned PANEL_HEIGHT = 320,
    parameter int unsigned HOLD_MS      = 100
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // raw sample input
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [9:0] raw_x, [19:10] raw_y, [29:20] raw_pressure, [61:30] time_ms, rest zero
    input  logic [rtef_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // filtered result output
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [9:0] pixel_x, [19:10] pixel_y, [29:20] pressure, [30] pressed,
    // [31] down_event, [32] up_event, [33] move_event, rest zero
    output logic [rtef_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // configuration write port
    input  logic                               i_cfg_wr_en,
    input  logic [rtef_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rtef_pkg::RAW_W-1:0]         i_cfg_data
);

    localparam int unsigned W  = rtef_pkg::RAW_W;
    localparam int unsigned TW = rtef_pkg::TIME_W;
    localparam int unsigned PW = rtef_pkg::PROD_W;
    localparam int unsigned CW = rtef_pkg::CNT_W;

    localparam logic [W-1:0]  SIZE_W  = W'(PANEL_WIDTH);
    localparam logic [W-1:0]  SIZE_H  = W'(PANEL_HEIGHT);
    localparam logic [TW-1:0] HOLD    = TW'(HOLD_MS);
    localparam logic [CW-1:0] DIV_END = CW'(PW - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [W-1:0]     r_cal_left, r_cal_right, r_cal_top, r_cal_bottom;
    logic [W-1:0]     r_p_min, r_p_max;
    rtef_pkg::t_orient r_orient;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_left   <= '0;
            r_cal_right  <= '1;
            r_cal_top    <= '0;
            r_cal_bottom <= '1;
            r_p_min      <= W'(10);
            r_p_max      <= W'(1000);
            r_orient     <= rtef_pkg::ORIENT_PORTRAIT;
        end else if (i_cfg_wr_en) begin
            unique case (rtef_pkg::t_cfg_idx'(i_cfg_index))
                rtef_pkg::CFG_CAL_LEFT:     r_cal_left   <= i_cfg_data;
                rtef_pkg::CFG_CAL_RIGHT:    r_cal_right  <= i_cfg_data;
                rtef_pkg::CFG_CAL_TOP:      r_cal_top    <= i_cfg_data;
                rtef_pkg::CFG_CAL_BOTTOM:   r_cal_bottom <= i_cfg_data;
                rtef_pkg::CFG_PRESSURE_MIN: r_p_min      <= i_cfg_data;
                rtef_pkg::CFG_PRESSURE_MAX: r_p_max      <= i_cfg_data;
                rtef_pkg::CFG_ORIENTATION:  r_orient     <= rtef_pkg::t_orient'(i_cfg_data[1:0]);
                default: ;  // drop writes to indexes past the list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input fields
    // ------------------------------------------------------------------
    logic [W-1:0]  in_raw_x, in_raw_y, in_raw_p;
    logic [TW-1:0] in_time;
    logic          in_touch;

    assign in_raw_x = i_s_axis_tdata[W-1:0];
    assign in_raw_y = i_s_axis_tdata[2*W-1:W];
    assign in_raw_p = i_s_axis_tdata[3*W-1:2*W];
    assign in_time  = i_s_axis_tdata[3*W+TW-1:3*W];
    // valid touch only with pressure strictly inside the window
    assign in_touch = (in_raw_p > r_p_min) && (in_raw_p < r_p_max);

    // ------------------------------------------------------------------
    // State machine
    // ------------------------------------------------------------------
    rtef_pkg::t_state r_state, n_state;
    logic             r_touch;     // current sample is a valid touch
    logic             r_axis;      // 0 maps pixel_x, 1 maps pixel_y
    logic [CW-1:0]    r_cnt;       // divider bit counter
    logic             r_out_valid;

    logic s_accept, out_free, out_load;

    assign out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rtef_pkg::ST_IDLE:
                if (i_s_axis_tvalid)
                    n_state = in_touch ? rtef_pkg::ST_SETUP : rtef_pkg::ST_DONE;
            rtef_pkg::ST_SETUP: n_state = rtef_pkg::ST_MUL;
            rtef_pkg::ST_MUL:   n_state = rtef_pkg::ST_DIV;
            rtef_pkg::ST_DIV:
                if (r_cnt == DIV_END) n_state = rtef_pkg::ST_STORE;
            rtef_pkg::ST_STORE:
                n_state = r_axis ? rtef_pkg::ST_DONE : rtef_pkg::ST_SETUP;
            rtef_pkg::ST_DONE:
                if (out_free) n_state = rtef_pkg::ST_IDLE;
            default: n_state = rtef_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == rtef_pkg::ST_IDLE);
        s_accept        = o_s_axis_tready && i_s_axis_tvalid;
        out_load        = (r_state == rtef_pkg::ST_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rtef_pkg::ST_IDLE;
            r_axis  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (s_accept) r_axis <= 1'b0;
            else if (r_state == rtef_pkg::ST_STORE) r_axis <= 1'b1;
            if (r_state == rtef_pkg::ST_MUL) r_cnt <= '0;
            else if (r_state == rtef_pkg::ST_DIV) r_cnt <= r_cnt + CW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Sample capture
    // ------------------------------------------------------------------
    logic [W-1:0]  r_raw_x, r_raw_y, r_raw_p;
    logic [TW-1:0] r_now;

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_raw_x <= in_raw_x;
            r_raw_y <= in_raw_y;
            r_raw_p <= in_raw_p;
            r_now   <= in_time;
            r_touch <= in_touch;
        end
    end

    // ------------------------------------------------------------------
    // Axis setup: pick raw reading, calibration ends and size for this axis
    // ------------------------------------------------------------------
    logic [W-1:0] sel_raw, sel_from, sel_to, sel_size;
    logic [W:0]   diff, span;

    always_comb begin
        unique case ({r_orient, r_axis})
            {rtef_pkg::ORIENT_PORTRAIT, 1'b0}: begin
                sel_raw = r_raw_x; sel_from = r_cal_left; sel_to = r_cal_right;
                sel_size = SIZE_W;
            end
            {rtef_pkg::ORIENT_PORTRAIT, 1'b1}: begin
                sel_raw = r_raw_y; sel_from = r_cal_top; sel_to = r_cal_bottom;
                sel_size = SIZE_H;
            end
            {rtef_pkg::ORIENT_LANDSCAPE, 1'b0}: begin
                sel_raw = r_raw_y; sel_from = r_cal_top; sel_to = r_cal_bottom;
                sel_size = SIZE_H;
            end
            {rtef_pkg::ORIENT_LANDSCAPE, 1'b1}: begin
                sel_raw = r_raw_x; sel_from = r_cal_right; sel_to = r_cal_left;
                sel_size = SIZE_W;
            end
            {rtef_pkg::ORIENT_PORTRAIT_INV, 1'b0}: begin
                sel_raw = r_raw_x; sel_from = r_cal_right; sel_to = r_cal_left;
                sel_size = SIZE_W;
            end
            {rtef_pkg::ORIENT_PORTRAIT_INV, 1'b1}: begin
                sel_raw = r_raw_y; sel_from = r_cal_bottom; sel_to = r_cal_top;
                sel_size = SIZE_H;
            end
            {rtef_pkg::ORIENT_LANDSCAPE_INV, 1'b0}: begin
                sel_raw = r_raw_y; sel_from = r_cal_bottom; sel_to = r_cal_top;
                sel_size = SIZE_H;
            end
            default: begin  // landscape inverted, pixel_y
                sel_raw = r_raw_x; sel_from = r_cal_left; sel_to = r_cal_right;
                sel_size = SIZE_W;
            end
        endcase
        diff = {1'b0, sel_raw} - {1'b0, sel_from};
        span = {1'b0, sel_to} - {1'b0, sel_from};
    end

    // ------------------------------------------------------------------
    // Datapath: magnitudes, product, bit-serial divide, clamp
    // ------------------------------------------------------------------
    logic [W-1:0]  r_mag, r_den, r_size, r_rem;
    logic          r_force_zero;    // zero span or negative quotient
    logic [PW-1:0] r_dvd;           // dividend, shifts out as quotient shifts in
    logic [W-1:0]  r_new_x, r_new_y;

    logic [W:0]    trial;
    logic          trial_ge;
    logic [W:0]    trial_sub;
    logic [W-1:0]  clamped;

    always_comb begin
        trial     = {r_rem, r_dvd[PW-1]};
        trial_ge  = trial >= {1'b0, r_den};
        trial_sub = trial - {1'b0, r_den};
        if (r_force_zero)
            clamped = '0;
        else if (r_dvd > {{(PW-W){1'b0}}, r_size})
            clamped = r_size;
        else
            clamped = r_dvd[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            rtef_pkg::ST_SETUP: begin
                r_mag        <= diff[W] ? W'(-diff) : diff[W-1:0];
                r_den        <= span[W] ? W'(-span) : span[W-1:0];
                r_size       <= sel_size;
                // a sign mismatch truncates to zero or below, which clamps to zero
                r_force_zero <= (span == '0) || (diff[W] ^ span[W]);
            end
            rtef_pkg::ST_MUL: begin
                r_dvd <= {{(PW-W){1'b0}}, r_mag} * {{(PW-W){1'b0}}, r_size};
                r_rem <= '0;
            end
            rtef_pkg::ST_DIV: begin
                r_rem <= trial_ge ? trial_sub[W-1:0] : trial[W-1:0];
                r_dvd <= {r_dvd[PW-2:0], trial_ge};
            end
            rtef_pkg::ST_STORE: begin
                if (r_axis) r_new_y <= clamped;
                else        r_new_x <= clamped;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Touch state, events and output register
    // ------------------------------------------------------------------
    logic [TW-1:0] r_last_time;
    logic [W-1:0]  r_cur_x, r_cur_y, r_cur_p;
    logic          r_was_pressed;
    logic [rtef_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic [TW-1:0] elapsed;
    logic          pressed, down_ev, up_ev, move_ev;
    logic [W-1:0]  nx, ny, np;

    always_comb begin
        elapsed = r_now - r_last_time;   // wraps modulo 2^32
        pressed = r_touch || (elapsed < HOLD);
        nx      = r_touch ? r_new_x : r_cur_x;
        ny      = r_touch ? r_new_y : r_cur_y;
        np      = r_touch ? r_raw_p : r_cur_p;
        down_ev = pressed && !r_was_pressed;
        up_ev   = !pressed && r_was_pressed;
        move_ev = pressed && ((nx != r_cur_x) || (ny != r_cur_y));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time   <= '0;
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_cur_p       <= '0;
            r_was_pressed <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (out_load) begin
                if (r_touch) r_last_time <= r_now;
                r_cur_x       <= nx;
                r_cur_y       <= ny;
                r_cur_p       <= np;
                r_was_pressed <= pressed;
                r_out_valid   <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load)
            r_out_data <= {6'b0, move_ev, up_ev, down_ev, pressed, np, ny, nx};
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
